@@ hdl/laser_scan_grid_rasterizer_assert.svh @@
// Assertion macros for the laser scan grid rasterizer.
`ifndef LASER_SCAN_GRID_RASTERIZER_ASSERT_SVH
`define LASER_SCAN_GRID_RASTERIZER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LSGR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define LSGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lsgr_pkg.sv @@
// Shared constants, widths and tables for the laser scan grid rasterizer.
`timescale 1ns / 1ps
package lsgr_pkg;

    // Port field widths
    localparam int CMD_W      = 2;
    localparam int RANGE_W    = 16;
    localparam int IDX_W      = 12;
    localparam int SEL_W      = 6;
    localparam int CELL_W     = 6;
    localparam int ROW_BITS_W = 64;
    localparam int ANGLE_W    = 16;

    // APB port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEAM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_MIN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE  = 2'd2;

    // Register reset values
    localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST  = 16'h8000;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST = 16'd64;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 16'd10240;

    // Sizing
    localparam int GRID_SIZE_DEF = 64;
    localparam int MAX_BEAMS     = 4096;

    // CORDIC
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 33;
    localparam int Z_W          = 32;
    localparam int RES_SHIFT    = 16;
    localparam logic signed [XY_W-1:0] CORDIC_START = 33'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D
    };

    // Shared multiplier
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = XY_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Cell division: floor(range*trig / 2^30) then floor(/20) by reciprocal.
    localparam int Q_SHIFT    = 30;
    localparam int Q_W        = 18;
    localparam int U_W        = 18;
    localparam int D_W        = 14;
    localparam int CELL_MM    = 20;
    localparam int DIV_BIAS   = 4096;
    localparam int DIV_OFFSET = CELL_MM * DIV_BIAS;
    localparam int DIV_SHIFT  = 23;
    localparam int DIV_MULT   = (2 ** DIV_SHIFT + CELL_MM - 1) / CELL_MM;

endpackage

@@ hdl/lsgr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsgr_ram #(
    parameter int WIDTH = lsgr_pkg::GRID_SIZE_DEF,
    parameter int DEPTH = lsgr_pkg::GRID_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lsgr_mul.sv @@
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module lsgr_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [lsgr_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [lsgr_pkg::MUL_B_W-1:0] i_b,
    output logic signed [lsgr_pkg::MUL_P_W-1:0] o_p
);
    import lsgr_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

@@ hdl/lsgr_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then quadrant map.
`timescale 1ns / 1ps
module lsgr_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lsgr_pkg::ANGLE_W-1:0]     i_angle,
    output logic                             o_done,
    output logic signed [lsgr_pkg::XY_W-1:0] o_cos,
    output logic signed [lsgr_pkg::XY_W-1:0] o_sin
);
    import lsgr_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    logic signed [XY_W-1:0] r_x, r_y, r_cos, r_sin;
    logic signed [Z_W-1:0]  r_z;
    logic [1:0]             r_quad;
    logic [ITER_W-1:0]      r_iter;
    logic                   r_run, r_map, r_done;

    logic signed [XY_W-1:0] sh_x, sh_y, step_x, step_y, map_c, map_s;
    logic signed [Z_W-1:0]  step_z;

    // One micro-rotation; >>> floors.
    always_comb begin
        sh_x = r_y >>> r_iter;
        sh_y = r_x >>> r_iter;
        if (!r_z[Z_W-1]) begin
            step_x = r_x - sh_x;
            step_y = r_y + sh_y;
            step_z = r_z - ATAN_TAB[r_iter];
        end else begin
            step_x = r_x + sh_x;
            step_y = r_y - sh_y;
            step_z = r_z + ATAN_TAB[r_iter];
        end
    end

    always_comb begin
        case (r_quad)
            QUAD_0: begin
                map_c = r_x;
                map_s = r_y;
            end
            QUAD_1: begin
                map_c = -r_y;
                map_s = r_x;
            end
            QUAD_2: begin
                map_c = -r_x;
                map_s = -r_y;
            end
            default: begin
                map_c = r_y;
                map_s = -r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_map  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_map  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (r_run) begin
            r_iter <= r_iter + 1'b1;
            if (r_iter == ITER_LAST) begin
                r_run <= 1'b0;
                r_map <= 1'b1;
            end
        end else if (r_map) begin
            r_map  <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_START;
            r_y    <= '0;
            r_z    <= $signed(Z_W'({i_angle[ANGLE_W-3:0], {RES_SHIFT{1'b0}}}));
            r_quad <= i_angle[ANGLE_W-1 -: 2];
        end else if (r_run) begin
            r_x <= step_x;
            r_y <= step_y;
            r_z <= step_z;
        end
        if (r_map) begin
            r_cos <= map_c;
            r_sin <= map_s;
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

@@ hdl/laser_scan_grid_rasterizer.sv @@
// Top level of the laser scan grid rasterizer: sequencer, registers and grid store.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_cmd, i_range_mm, i_range_invalid,
//                                           i_beam_index, i_row_select
//  output    out        o_valid / i_ready   o_hit, o_cell_row, o_cell_col, o_row_bits
//  config    in         APB psel/penable    paddr, pwdata, prdata, pready
//
//  One item in flight at a time; o_ready is high while the sequencer is idle.
//  Clear, no-op, rejected beams and reads of empty rows go straight to S_DONE. A
//  read of a written row passes S_ROW_RD and S_ROW_CAP. A beam passes S_LOAD,
//  S_ROT, S_MULC, S_MULS, S_DIVX, S_DIVY and S_BOUND, and one that lands in the
//  grid also S_RMW_RD and S_RMW_WR, using the 16-step CORDIC (one micro-rotation
//  a cycle) and five passes through the one shared multiplier.
//  Reset is synchronous; it drops every row valid bit, so no clearing pass runs.
//  The output register lets a finished result wait for i_ready while the next
//  item is accepted and worked on; a second result waits in S_DONE.
`timescale 1ns / 1ps
`include "laser_scan_grid_rasterizer_assert.svh"
module laser_scan_grid_rasterizer #(
    parameter int GRID_SIZE = lsgr_pkg::GRID_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lsgr_pkg::CMD_W-1:0]        i_cmd,
    input  logic [lsgr_pkg::RANGE_W-1:0]      i_range_mm,
    input  logic                              i_range_invalid,
    input  logic [lsgr_pkg::IDX_W-1:0]        i_beam_index,
    input  logic [lsgr_pkg::SEL_W-1:0]        i_row_select,
    // output channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_hit,
    output logic [lsgr_pkg::CELL_W-1:0]       o_cell_row,
    output logic [lsgr_pkg::CELL_W-1:0]       o_cell_col,
    output logic [lsgr_pkg::ROW_BITS_W-1:0]   o_row_bits,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsgr_pkg::PADDR_W-1:0]      paddr,
    input  logic [lsgr_pkg::PDATA_W-1:0]      pwdata,
    output logic [lsgr_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import lsgr_pkg::*;

    localparam int RW   = $clog2(GRID_SIZE);
    localparam int HALF = GRID_SIZE / 2;

    // Cell bounds expressed on the biased quotient (quotient + DIV_BIAS).
    localparam logic [D_W-1:0] ROW_LO   = D_W'(DIV_BIAS);
    localparam logic [D_W-1:0] ROW_HI   = D_W'(DIV_BIAS + GRID_SIZE);
    localparam logic [D_W-1:0] COL_TOP  = D_W'(DIV_BIAS + HALF);
    localparam logic [D_W-1:0] COL_BASE = D_W'(DIV_BIAS + HALF - GRID_SIZE);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_LOAD    = 13'b0000000000010,
        S_ROT     = 13'b0000000000100,
        S_MULC    = 13'b0000000001000,
        S_MULS    = 13'b0000000010000,
        S_DIVX    = 13'b0000000100000,
        S_DIVY    = 13'b0000001000000,
        S_BOUND   = 13'b0000010000000,
        S_RMW_RD  = 13'b0000100000000,
        S_RMW_WR  = 13'b0001000000000,
        S_ROW_RD  = 13'b0010000000000,
        S_ROW_CAP = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic signed [ANGLE_W-1:0] r_angle_min, r_angle_step;
    logic [RANGE_W-1:0]        r_max_range;
    logic [REG_IDX_W-1:0]      reg_idx;
    logic                      cfg_we;

    // Control state
    logic                 r_out_valid;
    logic [GRID_SIZE-1:0] r_row_written;

    // Item and datapath registers
    logic [RANGE_W-1:0] r_range;
    logic [RW-1:0]      r_sel, r_row, r_col;
    logic [U_W-1:0]     r_ux, r_uy;
    logic [D_W-1:0]     r_dx;

    // Staged result and output register
    logic                  r_res_hit, r_out_hit;
    logic [CELL_W-1:0]     r_res_row, r_res_col, r_out_row, r_out_col;
    logic [ROW_BITS_W-1:0] r_res_bits, r_out_bits;

    logic accept, out_load, beam_ok, read_ok, in_bounds;

    // Shared multiplier
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [IDX_W:0]            idx_inc;

    // CORDIC
    logic                   cordic_start, cordic_done;
    logic [ANGLE_W-1:0]     cordic_angle;
    logic signed [XY_W-1:0] cordic_cos, cordic_sin;

    // Division and bounds
    logic signed [Q_W:0] u_sum;
    logic [D_W-1:0]      dy, row_diff, col_diff;

    // Grid store
    logic                 ram_we, ram_re;
    logic [RW-1:0]        ram_raddr;
    logic [GRID_SIZE-1:0] ram_q, ram_wdata;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // A beam is worked on only if valid, in range and inside the scan.
    assign beam_ok = !i_range_invalid && (i_range_mm <= r_max_range)
                   && ({1'b0, i_beam_index} < (IDX_W + 1)'(MAX_BEAMS));
    // A row read touches the store only for a row inside the grid with data in it.
    assign read_ok = ({1'b0, i_row_select} < (SEL_W + 1)'(GRID_SIZE))
                   && r_row_written[i_row_select[RW-1:0]];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_ANGLE_MIN:  prdata = PDATA_W'($unsigned(r_angle_min));
            REG_ANGLE_STEP: prdata = PDATA_W'($unsigned(r_angle_step));
            REG_MAX_RANGE:  prdata = PDATA_W'(r_max_range);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd) inside
                        CMD_BEAM: n_state = beam_ok ? S_LOAD : S_DONE;
                        CMD_READ: n_state = read_ok ? S_ROW_RD : S_DONE;
                        CMD_CLEAR, CMD_NOP: n_state = S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD:    n_state = S_ROT;
            S_ROT:     n_state = cordic_done ? S_MULC : S_ROT;
            S_MULC:    n_state = S_MULS;
            S_MULS:    n_state = S_DIVX;
            S_DIVX:    n_state = S_DIVY;
            S_DIVY:    n_state = S_BOUND;
            S_BOUND:   n_state = in_bounds ? S_RMW_RD : S_DONE;
            S_RMW_RD:  n_state = S_RMW_WR;
            S_RMW_WR:  n_state = S_DONE;
            S_ROW_RD:  n_state = S_ROW_CAP;
            S_ROW_CAP: n_state = S_DONE;
            S_DONE:    n_state = out_load ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------- shared multiplier operands ----------------
    // Angle product on accept, then range*cos, range*sin, and the two
    // reciprocal multiplies for the divide by the cell size.
    assign idx_inc = (IDX_W + 1)'(i_beam_index) + 1'b1;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_IDLE: begin
                mul_en = accept && (i_cmd == CMD_BEAM);
                mul_a  = $signed(MUL_A_W'(idx_inc));
                mul_b  = MUL_B_W'(r_angle_step);
            end
            S_MULC: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_A_W'(r_range));
                mul_b  = cordic_cos;
            end
            S_MULS: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_A_W'(r_range));
                mul_b  = cordic_sin;
            end
            S_DIVX: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_A_W'(r_ux));
                mul_b  = $signed(MUL_B_W'(DIV_MULT));
            end
            S_DIVY: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_A_W'(r_uy));
                mul_b  = $signed(MUL_B_W'(DIV_MULT));
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    lsgr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // ---------------- CORDIC ----------------
    // Low 16 bits of step*(index+1) plus the start angle wrap modulo a turn.
    assign cordic_start = (r_state == S_LOAD);
    assign cordic_angle = mul_p[ANGLE_W-1:0] + $unsigned(r_angle_min);

    lsgr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (cordic_angle),
        .o_done  (cordic_done),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin)
    );

    // ---------------- cell arithmetic ----------------
    // Floor by 2^30 is a part-select; a bias keeps the value positive so the
    // reciprocal multiply floors the divide by 20 exactly.
    assign u_sum    = (Q_W + 1)'($signed(mul_p[Q_SHIFT +: Q_W])) + (Q_W + 1)'(DIV_OFFSET);
    assign dy       = mul_p[DIV_SHIFT +: D_W];
    assign row_diff = r_dx - ROW_LO;
    assign col_diff = COL_TOP - dy;
    assign in_bounds = (r_dx >= ROW_LO) && (r_dx < ROW_HI)
                     && (dy <= COL_TOP) && (dy > COL_BASE);

    // ---------------- grid store ----------------
    // Read-modify-write: a row without its valid bit counts as all zero.
    assign ram_re    = (r_state == S_RMW_RD) || (r_state == S_ROW_RD);
    assign ram_raddr = (r_state == S_ROW_RD) ? r_sel : r_row;
    assign ram_we    = (r_state == S_RMW_WR);
    assign ram_wdata = (r_row_written[r_row] ? ram_q : '0) | (GRID_SIZE'(1) << r_col);

    lsgr_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_row_written <= '0;
            r_angle_min   <= $signed(ANGLE_MIN_RST);
            r_angle_step  <= $signed(ANGLE_STEP_RST);
            r_max_range   <= MAX_RANGE_RST;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept && (i_cmd == CMD_CLEAR)) begin
                r_row_written <= '0;
            end else if (ram_we) begin
                r_row_written[r_row] <= 1'b1;
            end
            if (cfg_we) begin
                unique case (reg_idx)
                    REG_ANGLE_MIN:  r_angle_min  <= $signed(pwdata[ANGLE_W-1:0]);
                    REG_ANGLE_STEP: r_angle_step <= $signed(pwdata[ANGLE_W-1:0]);
                    REG_MAX_RANGE:  r_max_range  <= pwdata[RANGE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_range    <= i_range_mm;
            r_sel      <= i_row_select[RW-1:0];
            r_res_hit  <= 1'b0;
            r_res_row  <= '0;
            r_res_col  <= '0;
            r_res_bits <= '0;
        end
        if (r_state == S_MULS) begin
            r_ux <= u_sum[U_W-1:0];
        end
        if (r_state == S_DIVX) begin
            r_uy <= u_sum[U_W-1:0];
        end
        if (r_state == S_DIVY) begin
            r_dx <= mul_p[DIV_SHIFT +: D_W];
        end
        if ((r_state == S_BOUND) && in_bounds) begin
            r_row     <= row_diff[RW-1:0];
            r_col     <= col_diff[RW-1:0];
            r_res_hit <= 1'b1;
            r_res_row <= CELL_W'(row_diff[RW-1:0]);
            r_res_col <= CELL_W'(col_diff[RW-1:0]);
        end
        if (r_state == S_ROW_CAP) begin
            r_res_bits <= ROW_BITS_W'(ram_q);
        end
        if (out_load) begin
            r_out_hit  <= r_res_hit;
            r_out_row  <= r_res_row;
            r_out_col  <= r_res_col;
            r_out_bits <= r_res_bits;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_hit      = r_out_hit;
    assign o_cell_row = r_out_row;
    assign o_cell_col = r_out_col;
    assign o_row_bits = r_out_bits;

    // ---------------- assertions ----------------
    `LSGR_ASSERT_NEXT(a_clear_drops_rows, i_clk, i_rst_n,
        accept && (i_cmd == CMD_CLEAR), r_row_written == '0,
        "clear left a row marked written")
    `LSGR_ASSERT_NEXT(a_write_marks_row, i_clk, i_rst_n,
        ram_we, r_row_written[r_row],
        "grid row written without its valid bit")
    `LSGR_ASSERT_NOW(a_miss_no_cell, i_clk, i_rst_n,
        o_valid && !o_hit, (o_cell_row == '0) && (o_cell_col == '0),
        "miss result carries a cell")
    `LSGR_ASSERT_NOW(a_row_read_no_hit, i_clk, i_rst_n,
        o_valid && (o_row_bits != '0), !o_hit,
        "row read result flagged as hit")

endmodule
